// ===== hw/rtl/etl_pkg.sv =====
package etl_pkg;

  localparam int unsigned MaxSourceLengthDefault = 65536;

  localparam int unsigned ModeW = 4;
  localparam int unsigned PosW  = 16;
  localparam int unsigned TypeW = 5;
  localparam int unsigned PrefixW = 40;

  // scan modes
  localparam logic [ModeW-1:0] ModeIdle    = 4'd0;
  localparam logic [ModeW-1:0] ModeGt      = 4'd1;
  localparam logic [ModeW-1:0] ModeLt      = 4'd2;
  localparam logic [ModeW-1:0] ModeBang    = 4'd3;
  localparam logic [ModeW-1:0] ModeEq      = 4'd4;
  localparam logic [ModeW-1:0] ModeNum     = 4'd5;
  localparam logic [ModeW-1:0] ModeIdent   = 4'd6;
  localparam logic [ModeW-1:0] ModeStr     = 4'd7;
  localparam logic [ModeW-1:0] ModeEsc     = 4'd8;
  localparam logic [ModeW-1:0] ModeComment = 4'd9;

  // token types
  localparam logic [TypeW-1:0] TokEof     = 5'd0;
  localparam logic [TypeW-1:0] TokPlus    = 5'd1;
  localparam logic [TypeW-1:0] TokMinus   = 5'd2;
  localparam logic [TypeW-1:0] TokStar    = 5'd3;
  localparam logic [TypeW-1:0] TokSlash   = 5'd4;
  localparam logic [TypeW-1:0] TokLParen  = 5'd5;
  localparam logic [TypeW-1:0] TokRParen  = 5'd6;
  localparam logic [TypeW-1:0] TokComma   = 5'd7;
  localparam logic [TypeW-1:0] TokColon   = 5'd8;
  localparam logic [TypeW-1:0] TokGt      = 5'd9;
  localparam logic [TypeW-1:0] TokGe      = 5'd10;
  localparam logic [TypeW-1:0] TokLt      = 5'd11;
  localparam logic [TypeW-1:0] TokLe      = 5'd12;
  localparam logic [TypeW-1:0] TokNe      = 5'd13;
  localparam logic [TypeW-1:0] TokEqEq    = 5'd14;
  localparam logic [TypeW-1:0] TokAssign  = 5'd15;
  localparam logic [TypeW-1:0] TokString  = 5'd16;
  localparam logic [TypeW-1:0] TokInt     = 5'd17;
  localparam logic [TypeW-1:0] TokIdent   = 5'd18;
  localparam logic [TypeW-1:0] TokPrint   = 5'd19;
  localparam logic [TypeW-1:0] TokIf      = 5'd20;
  localparam logic [TypeW-1:0] TokElse    = 5'd21;
  localparam logic [TypeW-1:0] TokUnknown = 5'd22;
  localparam logic [TypeW-1:0] TokUnterm  = 5'd23;

  // keywords, first character in the low byte
  localparam logic [PrefixW-1:0] KwPrint = 40'h746E697270;
  localparam logic [PrefixW-1:0] KwIf    = 40'h0000006669;
  localparam logic [PrefixW-1:0] KwElse  = 40'h0065736C65;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [PosW-1:0]    pos;
    logic [PosW-1:0]    start;
    logic [PosW-1:0]    len;
    logic [PrefixW-1:0] prefix;
  } scan_state_t;

  typedef struct packed {
    logic               last;
    logic [PosW-1:0]    len;
    logic [PosW-1:0]    start;
    logic [TypeW-1:0]   ttype;
  } token_t;

endpackage

// ===== hw/rtl/etl_scan.sv =====
module etl_scan import etl_pkg::*; #(
  parameter int unsigned MAX_SOURCE_LENGTH = MaxSourceLengthDefault
) (
  input  scan_state_t st_i,
  input  logic        end_i,
  input  logic [7:0]  char_i,
  output scan_state_t st_o,
  output token_t      tok0_o,
  output token_t      tok1_o,
  output logic [1:0]  tok_cnt_o
);

  localparam logic [PosW-1:0] PosLimit = (MAX_SOURCE_LENGTH - 1 > 65535) ? 16'hFFFF :
                                         PosW'(MAX_SOURCE_LENGTH - 1);
  localparam logic [PosW-1:0] LenLimit = 16'hFFFF;

  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLf     = 8'h0A;

  function automatic logic [PrefixW-1:0] grow_prefix(logic [PrefixW-1:0] p,
                                                      logic [PosW-1:0] l,
                                                      logic [7:0] c);
    logic [PrefixW-1:0] r;
    r = p;
    if (l < 16'd5) begin
      unique case (l[2:0])
        3'd0:    r[7:0]   = r[7:0]   | c;
        3'd1:    r[15:8]  = r[15:8]  | c;
        3'd2:    r[23:16] = r[23:16] | c;
        3'd3:    r[31:24] = r[31:24] | c;
        default: r[39:32] = r[39:32] | c;
      endcase
    end
    return r;
  endfunction

  function automatic logic [TypeW-1:0] word_type(scan_state_t s);
    logic [TypeW-1:0] t;
    t = TokIdent;
    if (s.mode == ModeNum) t = TokInt;
    else if (s.len == 16'd5 && s.prefix == KwPrint) t = TokPrint;
    else if (s.len == 16'd2 && s.prefix == KwIf) t = TokIf;
    else if (s.len == 16'd4 && s.prefix == KwElse) t = TokElse;
    return t;
  endfunction

  logic            is_digit, is_alpha, is_space;
  logic [PosW-1:0] len_inc;
  logic [PrefixW-1:0] prefix_grown;
  logic            e0_v, e1_v, scan_idle;
  token_t          e0, e1;
  scan_state_t     s;
  logic [PosW-1:0] pos;

  assign is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_alpha = ((char_i >= 8'h61) && (char_i <= 8'h7A)) ||
                    ((char_i >= 8'h41) && (char_i <= 8'h5A));
  assign is_space = (char_i == 8'h20) || ((char_i >= 8'h09) && (char_i <= 8'h0D));
  assign len_inc  = (st_i.len < LenLimit) ? st_i.len + 16'd1 : st_i.len;
  assign prefix_grown = grow_prefix(st_i.prefix, st_i.len, char_i);

  always_comb begin
    s         = st_i;
    pos       = st_i.pos;
    e0_v      = 1'b0;
    e1_v      = 1'b0;
    e0        = '0;
    e1        = '0;
    scan_idle = 1'b0;

    if (end_i) begin
      // flush the open token, then eof; return to reset state
      e0.start = st_i.start;
      e0.len   = st_i.len;
      unique case (st_i.mode)
        ModeGt:    begin e0_v = 1'b1; e0.ttype = TokGt;     e0.len = 16'd1; end
        ModeLt:    begin e0_v = 1'b1; e0.ttype = TokLt;     e0.len = 16'd1; end
        ModeEq:    begin e0_v = 1'b1; e0.ttype = TokAssign; e0.len = 16'd1; end
        ModeNum, ModeIdent: begin e0_v = 1'b1; e0.ttype = word_type(st_i); end
        ModeStr, ModeEsc:   begin e0_v = 1'b1; e0.ttype = TokUnterm; end
        default: ;
      endcase
      e1_v     = 1'b1;
      e1.ttype = TokEof;
      e1.start = st_i.pos;
      e1.len   = '0;
      s        = '0;
    end else begin
      if (st_i.pos < PosLimit) s.pos = st_i.pos + 16'd1;
      e0.start = st_i.start;
      e0.len   = st_i.len;
      unique case (st_i.mode)
        ModeGt, ModeLt, ModeBang, ModeEq: begin
          s.mode = ModeIdle;
          if (char_i == ChEq) begin
            e0_v   = 1'b1;
            e0.len = 16'd2;
            unique case (st_i.mode)
              ModeGt:   e0.ttype = TokGe;
              ModeLt:   e0.ttype = TokLe;
              ModeBang: e0.ttype = TokNe;
              default:  e0.ttype = TokEqEq;
            endcase
          end else begin
            scan_idle = 1'b1;
            e0_v      = (st_i.mode != ModeBang);
            e0.len    = 16'd1;
            unique case (st_i.mode)
              ModeGt:  e0.ttype = TokGt;
              ModeLt:  e0.ttype = TokLt;
              default: e0.ttype = TokAssign;
            endcase
          end
        end
        ModeNum, ModeIdent: begin
          if (is_digit || is_alpha) begin
            if (is_alpha) s.mode = ModeIdent;
            s.len    = len_inc;
            s.prefix = prefix_grown;
          end else begin
            e0_v      = 1'b1;
            e0.ttype  = word_type(st_i);
            s.mode    = ModeIdle;
            scan_idle = 1'b1;
          end
        end
        ModeStr: begin
          if (char_i == ChQuote) begin
            e0_v     = 1'b1;
            e0.ttype = TokString;
            s.mode   = ModeIdle;
          end else begin
            if (char_i == ChBslash) s.mode = ModeEsc;
            s.len    = len_inc;
            s.prefix = prefix_grown;
          end
        end
        ModeEsc: begin
          s.mode   = ModeStr;
          s.len    = len_inc;
          s.prefix = prefix_grown;
        end
        ModeComment: begin
          if (char_i == ChLf) s.mode = ModeIdle;
        end
        default: begin
          s.mode    = ModeIdle;
          scan_idle = 1'b1;
        end
      endcase

      if (scan_idle) begin
        e1.start = pos;
        e1.len   = 16'd1;
        unique case (char_i)
          ChPlus:   begin e1_v = 1'b1; e1.ttype = TokPlus;   end
          ChMinus:  begin e1_v = 1'b1; e1.ttype = TokMinus;  end
          ChStar:   begin e1_v = 1'b1; e1.ttype = TokStar;   end
          ChSlash:  begin e1_v = 1'b1; e1.ttype = TokSlash;  end
          ChLParen: begin e1_v = 1'b1; e1.ttype = TokLParen; end
          ChRParen: begin e1_v = 1'b1; e1.ttype = TokRParen; end
          ChComma:  begin e1_v = 1'b1; e1.ttype = TokComma;  end
          ChColon:  begin e1_v = 1'b1; e1.ttype = TokColon;  end
          ChGt, ChLt, ChBang, ChEq: begin
            unique case (char_i)
              ChGt:    s.mode = ModeGt;
              ChLt:    s.mode = ModeLt;
              ChBang:  s.mode = ModeBang;
              default: s.mode = ModeEq;
            endcase
            s.start  = pos;
            s.len    = '0;
            s.prefix = '0;
          end
          ChQuote: begin
            s.mode   = ModeStr;
            s.start  = (pos < PosLimit) ? pos + 16'd1 : PosLimit;
            s.len    = '0;
            s.prefix = '0;
          end
          ChHash: s.mode = ModeComment;
          default: begin
            if (is_digit || is_alpha) begin
              s.mode   = is_digit ? ModeNum : ModeIdent;
              s.start  = pos;
              s.len    = 16'd1;
              s.prefix = {32'd0, char_i};
            end else if (!is_space) begin
              e1_v     = 1'b1;
              e1.ttype = TokUnknown;
            end
          end
        endcase
      end
    end
  end

  // pack the emitted tokens in order and mark the final one
  always_comb begin
    tok0_o = e0_v ? e0 : e1;
    tok1_o = e1;
    tok0_o.last = !(e0_v && e1_v);
    tok1_o.last = 1'b1;
    tok_cnt_o   = {1'b0, e0_v} + {1'b0, e1_v};
  end

  assign st_o = s;

endmodule

// ===== hw/rtl/etl_tok_fifo.sv =====
module etl_tok_fifo import etl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  token_t     wr0_i,
  input  token_t     wr1_i,
  input  logic [1:0] wr_cnt_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       pop_i,
  output token_t     head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q;
  logic              pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // two free entries guarantee space for the worst-case word
  assign room_o  = (cnt_q <= (PtrW+1)'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) mem_q[wr_ptr_q] <= wr0_i;
    if (wr_cnt_i == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(wr_cnt_i);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(wr_cnt_i) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/expression_token_lexer_unit.sv =====
// A token is written into the token queue register when its source byte is taken.
// Throughput: one source byte per cycle; a byte that yields two tokens writes both
// to the queue at once, and the four-entry token queue stalls input only when it holds
// more than two tokens.
// Reset (rst_ni low, asynchronous): scan state idle, position zero, token queue empty.
module expression_token_lexer_unit import etl_pkg::*; #(
  parameter int unsigned MAX_SOURCE_LENGTH = MaxSourceLengthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] command (0 char, 1 end of source)
  // token stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] token_type, [20:5] token_start,
                                      // [36:21] token_length, [39:37] zero
  output logic        m_axis_tlast    // last_of_run
);

  scan_state_t st_q, st_d;
  token_t      tok0, tok1, head;
  logic [1:0]  tok_cnt, wr_cnt;
  logic        accept, room;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Scan one word against the held state: close any pending token, then treat the byte as a
  // fresh start if the pending token did not absorb it; at end of source, flush it and add eof.
  etl_scan #(
    .MAX_SOURCE_LENGTH (MAX_SOURCE_LENGTH)
  ) u_scan (
    .st_i      (st_q),
    .end_i     (s_axis_tuser),
    .char_i    (s_axis_tdata),
    .st_o      (st_d),
    .tok0_o    (tok0),
    .tok1_o    (tok1),
    .tok_cnt_o (tok_cnt)
  );

  // Advance the scanner only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  assign wr_cnt = accept ? tok_cnt : 2'd0;

  // Hold finished tokens until the sink takes them.
  etl_tok_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr0_i    (tok0),
    .wr1_i    (tok1),
    .wr_cnt_i (wr_cnt),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {3'b000, head.len, head.start, head.ttype};
  assign m_axis_tlast = head.last;

endmodule
